[src/sdsr_pkg.sv]
// ----------------------------------------------------------------------------
// sdsr_pkg
// shared types and constants of the sub-pixel dot stamp row generator
// ----------------------------------------------------------------------------
package sdsr_pkg;

  localparam int MaskW    = 16;
  localparam int PosW     = 16;
  localparam int CoordW   = 15;
  localparam int ColorW   = 32;
  localparam int DimW     = 14;
  localparam int RadW     = 3;
  localparam int IdxW     = 4;
  localparam int RadMin   = 3;
  localparam int RadHard  = 7;

  localparam int MaxRadiusDef    = 7;
  localparam int SubpixelBitsDef = 2;

  localparam int InDataW  = 64;
  localparam int InUserW  = 2;
  localparam int OutDataW = 80;
  localparam int OutPadW  = OutDataW - 2 * CoordW - MaskW - ColorW;

  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  localparam logic [1:0] REG_DOT_RADIUS    = 2'd0;
  localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd1;
  localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd2;

  localparam logic [RadW-1:0] DotRadiusRst    = 3'd7;
  localparam logic [DimW-1:0] WindowWidthRst  = 14'd3840;
  localparam logic [DimW-1:0] WindowHeightRst = 14'd2160;

  typedef enum logic [1:0] {
    SHAPE_CIRCLE = 2'd0,
    SHAPE_RING   = 2'd1,
    SHAPE_CROSS  = 2'd2
  } shape_e;

  typedef struct packed {
    logic [CoordW-1:0] row_y;
    logic [CoordW-1:0] row_left;
    logic [ColorW-1:0] color;
    logic              last;
    logic              row_ok;
    shape_e            shape;
  } side_t;

endpackage

[src/subpixel_dot_sprite_rows_top.sv]
// ----------------------------------------------------------------------------
// subpixel_dot_sprite_rows_top
// stamps one sub-pixel dot as 2r+2 masked rows, circle, ring or diagonal cross
// ----------------------------------------------------------------------------
//  channel   dir   beat                     fields (low bit first)
//  s_axis    in    one dot                  tdata: x_quarter, y_quarter, paint_color
//                                           tuser: shape
//  m_axis    out   one stamp row            tdata: row_y, row_left, pixel_mask, row_color
//                                           tlast: last_row
//  apb       in    register write and read  dot_radius, window_width, window_height
//
//  one row a cycle while m_axis is not stalled; a dot of radius r gives 2r+2 rows at the row sequencer
//  the next dot is taken in the cycle its predecessor's last row leaves the sequencer
//  the first row of a dot passes the sequencer registers and every stage register before it shows on m_axis
//  reset clears valid bits and registers to 7, 3840, 2160
//  while m_axis_tvalid is high and m_axis_tready low all stages hold
// ----------------------------------------------------------------------------
module subpixel_dot_sprite_rows_top
  import sdsr_pkg::*;
#(
  parameter int MAX_RADIUS    = MaxRadiusDef,
  parameter int SUBPIXEL_BITS = SubpixelBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // x_quarter, y_quarter, paint_color
  input  logic [InUserW-1:0]  s_axis_tuser,   // shape
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // row_y, row_left, pixel_mask, row_color
  output logic                m_axis_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int SB  = SUBPIXEL_BITS;
  localparam int AW  = IdxW + SB;
  localparam int DW  = AW + 1;
  localparam int SQW = 2 * AW;
  localparam int CW  = SQW + 2;
  localparam int PW  = PosW + 1;

  localparam logic [RadW-1:0] RadTop = RadW'(MAX_RADIUS > RadHard ? RadHard : MAX_RADIUS);
  localparam logic [RadW-1:0] RadLow = RadW'(RadMin);
  localparam logic [CW-1:0]   SubSq  = CW'(1) << (2 * SB);

  // configuration registers
  logic [RadW-1:0] dot_radius_q;
  logic [DimW-1:0] win_w_q, win_h_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_radius_q <= DotRadiusRst;
      win_w_q      <= WindowWidthRst;
      win_h_q      <= WindowHeightRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DOT_RADIUS:    dot_radius_q <= pwdata[RadW-1:0];
        REG_WINDOW_WIDTH:  win_w_q      <= pwdata[DimW-1:0];
        REG_WINDOW_HEIGHT: win_h_q      <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DOT_RADIUS:    prdata = ApbDataW'(dot_radius_q);
      REG_WINDOW_WIDTH:  prdata = ApbDataW'(win_w_q);
      REG_WINDOW_HEIGHT: prdata = ApbDataW'(win_h_q);
      default:           prdata = '0;
    endcase
  end

  logic [RadW-1:0] r_eff;
  assign r_eff = (dot_radius_q < RadLow) ? RadLow :
                 (dot_radius_q > RadTop) ? RadTop : dot_radius_q;

  // row sequencer
  logic                   adv, issue, seq_last, acc;
  logic                   busy_q;
  logic [IdxW-1:0]        idx_q, lastidx_q;
  logic [RadW-1:0]        r_q;
  logic signed [PW-1:0]   px_q, py_q;
  logic [SB-1:0]          sx_q, sy_q;
  shape_e                 shape_q;
  logic [ColorW-1:0]      color_q;
  logic                   v1_q, v2_q, v3_q, v4_q;

  assign adv           = ~v4_q | m_axis_tready;
  assign issue         = busy_q & adv;
  assign seq_last      = (idx_q == lastidx_q);
  assign s_axis_tready = adv & (~busy_q | seq_last);
  assign acc           = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (acc) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (issue) begin
      if (seq_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      r_q       <= r_eff;
      lastidx_q <= {r_eff, 1'b1};
      px_q      <= {{(SB + 1){s_axis_tdata[PosW-1]}}, s_axis_tdata[PosW-1:SB]};
      py_q      <= {{(SB + 1){s_axis_tdata[2*PosW-1]}}, s_axis_tdata[2*PosW-1:PosW+SB]};
      sx_q      <= s_axis_tdata[SB-1:0];
      sy_q      <= s_axis_tdata[PosW+SB-1:PosW];
      shape_q   <= shape_e'(s_axis_tuser);
      color_q   <= s_axis_tdata[InDataW-1:2*PosW];
    end
  end

  // stage 1: row position, clipping, vertical offset, thresholds
  logic [5:0]             rsq;
  logic signed [PW-1:0]   row_d, left_d;
  logic [MaskW-1:0]       colok_d;
  logic [DW-1:0]          dy_d;
  side_t                  side1_q, side2_q, side3_q, side4_q;
  logic [MaskW-1:0]       colok1_q, colok2_q, colok3_q;
  logic [DW-1:0]          dy1_q;
  logic [RadW-1:0]        r1_q;
  logic [SB-1:0]          sx1_q;
  logic [CW-1:0]          thin1_q, thring1_q, thx1_q;
  logic [CW-1:0]          thin2_q, thring2_q, thx2_q;
  logic [CW-1:0]          thin3_q, thring3_q, thx3_q;

  assign rsq    = 6'(r_q) * 6'(r_q);
  assign left_d = px_q - $signed({{(PW - RadW){1'b0}}, r_q});
  assign row_d  = py_q - $signed({{(PW - RadW){1'b0}}, r_q})
                       + $signed({{(PW - IdxW){1'b0}}, idx_q});
  assign dy_d   = DW'({idx_q, {SB{1'b0}}}) - DW'({r_q, {SB{1'b0}}}) - DW'(sy_q);

  for (genvar j = 0; j < MaskW; j++) begin : g_colok
    logic signed [PW-1:0] col;
    assign col        = left_d + $signed(PW'(j));
    assign colok_d[j] = ~col[PW-1] && (col < $signed({{(PW - DimW){1'b0}}, win_w_q}))
                        && (IdxW'(j) <= lastidx_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q.row_y    <= row_d[CoordW-1:0];
      side1_q.row_left <= left_d[CoordW-1:0];
      side1_q.color    <= color_q;
      side1_q.last     <= seq_last;
      side1_q.row_ok   <= ~row_d[PW-1] && (row_d < $signed({{(PW - DimW){1'b0}}, win_h_q}));
      side1_q.shape    <= shape_q;
      colok1_q         <= colok_d;
      dy1_q            <= dy_d;
      r1_q             <= r_q;
      sx1_q            <= sx_q;
      thin1_q          <= CW'(rsq) << (2 * SB);
      thring1_q        <= CW'(rsq >> 1) << (2 * SB);
      thx1_q           <= CW'(rsq) << (2 * SB + 1);
    end
  end

  // stage 2: per-column offsets and squares
  logic [AW-1:0]  b2;
  logic [SQW-1:0] dysq2_q;
  logic [SQW-1:0] dxsq2_q [MaskW];
  logic [AW:0]    ab2_q   [MaskW];
  logic [AW-1:0]  m2_q    [MaskW];

  assign b2 = dy1_q[DW-1] ? AW'(-dy1_q) : AW'(dy1_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q   <= side1_q;
      colok2_q  <= colok1_q;
      dysq2_q   <= SQW'(b2) * SQW'(b2);
      thin2_q   <= thin1_q;
      thring2_q <= thring1_q;
      thx2_q    <= thx1_q;
    end
  end

  // stage 3: distance and sector terms
  logic [SQW:0]   d3_q    [MaskW];
  logic [CW-1:0]  sum3_q  [MaskW];
  logic [SQW:0]   mm3_q   [MaskW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q   <= side2_q;
      colok3_q  <= colok2_q;
      thin3_q   <= thin2_q;
      thring3_q <= thring2_q;
      thx3_q    <= thx2_q;
    end
  end

  // stage 4: shape tests and mask
  logic [MaskW-1:0] hit;
  logic [MaskW-1:0] mask4_q;

  for (genvar j = 0; j < MaskW; j++) begin : g_lane
    localparam logic [DW-1:0] JOff = DW'(j << SB);
    logic [DW-1:0]  dx;
    logic [AW-1:0]  a;
    logic [SQW-1:0] msq;
    logic [CW-1:0]  dext;

    assign dx  = JOff - DW'({r1_q, {SB{1'b0}}}) - DW'(sx1_q);
    assign a   = dx[DW-1] ? AW'(-dx) : AW'(dx);
    assign msq = SQW'(m2_q[j]) * SQW'(m2_q[j]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dxsq2_q[j] <= SQW'(a) * SQW'(a);
        ab2_q[j]   <= (AW + 1)'(a) + (AW + 1)'(b2);
        m2_q[j]    <= (a > b2) ? a : b2;
        d3_q[j]    <= (SQW + 1)'(dxsq2_q[j]) + (SQW + 1)'(dysq2_q);
        sum3_q[j]  <= CW'(ab2_q[j]) * CW'(ab2_q[j]);
        mm3_q[j]   <= {msq, 1'b0};
      end
    end

    assign dext = CW'(d3_q[j]);

    always_comb begin
      case (side3_q.shape)
        SHAPE_CIRCLE: hit[j] = (dext <= thin3_q);
        SHAPE_RING:   hit[j] = (dext <= thin3_q) && (dext >= thring3_q);
        SHAPE_CROSS:  hit[j] = (dext <= SubSq)
                               || ((dext <= thx3_q) && (sum3_q[j] > CW'(mm3_q[j])));
        default:      hit[j] = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side4_q <= side3_q;
      mask4_q <= hit & colok3_q & {MaskW{side3_q.row_ok}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tlast  = side4_q.last;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, side4_q.color, mask4_q,
                          side4_q.row_left, side4_q.row_y};

endmodule

[src/sdsr_checker.sv]
// ----------------------------------------------------------------------------
// sdsr_checker
// port-level checks on the row stream of the dot stamp generator
// ----------------------------------------------------------------------------
module sdsr_checker
  import sdsr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,   // row_y, row_left, pixel_mask, row_color
  input logic                m_axis_tlast
);

  logic mid_beat;
  assign mid_beat = m_axis_tvalid & m_axis_tready & ~m_axis_tlast;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("row beat changed while stalled");

  a_rows_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_beat |=> m_axis_tvalid)
    else $error("gap inside the rows of one dot");

  a_same_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_beat |=>
      (m_axis_tdata[2*CoordW-1:CoordW] == $past(m_axis_tdata[2*CoordW-1:CoordW])) &&
      (m_axis_tdata[OutDataW-OutPadW-1:2*CoordW+MaskW] ==
       $past(m_axis_tdata[OutDataW-OutPadW-1:2*CoordW+MaskW])))
    else $error("left column or colour changed within a dot");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_beat |=>
      m_axis_tdata[CoordW-1:0] == $past(m_axis_tdata[CoordW-1:0]) + CoordW'(1))
    else $error("row does not advance by one");

endmodule

bind subpixel_dot_sprite_rows_top sdsr_checker u_sdsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sub-pixel dot stamp row generator: dots are
// offered on s_axis under random and back-to-back timing, every dot is
// expanded into its expected stamp rows by a behavioural predictor, and each
// row beat on m_axis is compared field by field, across several register
// settings written over apb between phases
// ----------------------------------------------------------------------------
module tb;
  import sdsr_pkg::*;

  localparam int          ClkPeriod    = 4;
  localparam int          HoldLen      = 200;
  localparam int          SettleCycles = 8;
  localparam logic [1:0]  ShapeUnknown = 2'd3;

  typedef struct packed {
    logic              last;
    logic [ColorW-1:0] color;
    logic [MaskW-1:0]  mask;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] row_y;
  } stamp_row_t;

  class stamp_scoreboard;
    int radius;
    int width;
    int height;
    int mismatches;
    stamp_row_t rows_due[$];

    function new();
      radius     = DotRadiusRst;
      width      = WindowWidthRst;
      height     = WindowHeightRst;
      mismatches = 0;
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    // expand one dot into its 2r+2 stamp rows
    function void note_dot(logic [InDataW-1:0] data, logic [InUserW-1:0] shp);
      int xq, yq, r, n, s, s2, px, py, sx, sy, left, row, col;
      int dx, dy, d, a, b, m;
      bit hit;
      logic [MaskW-1:0] mask;
      stamp_row_t e;
      xq = $signed(data[15:0]);
      yq = $signed(data[31:16]);
      r  = radius;
      if (r < RadMin) r = RadMin;
      if (r > MaxRadiusDef) r = MaxRadiusDef;
      n  = 2 * r + 2;
      s  = 1 << SubpixelBitsDef;
      s2 = s * s;
      px = xq >>> SubpixelBitsDef;
      py = yq >>> SubpixelBitsDef;
      sx = xq & (s - 1);
      sy = yq & (s - 1);
      left = px - r;
      for (int i = 0; i < n; i++) begin
        row  = py - r + i;
        mask = '0;
        if (row >= 0 && row < height) begin
          for (int j = 0; j < n; j++) begin
            col = left + j;
            dx  = j * s - (r * s + sx);
            dy  = i * s - (r * s + sy);
            d   = dx * dx + dy * dy;
            a   = dx < 0 ? -dx : dx;
            b   = dy < 0 ? -dy : dy;
            m   = a > b ? a : b;
            case (shp)
              SHAPE_CIRCLE: hit = d <= r * r * s2;
              SHAPE_RING:   hit = d <= r * r * s2 && d >= ((r * r) / 2) * s2;
              SHAPE_CROSS:  hit = d <= s2 ||
                                  (d <= 2 * r * r * s2 && (a + b) * (a + b) > 2 * m * m);
              default:      hit = 1'b0;
            endcase
            if (col >= 0 && col < width && hit) mask[j] = 1'b1;
          end
        end
        e.row_y = row[CoordW-1:0];
        e.left  = left[CoordW-1:0];
        e.mask  = mask;
        e.color = data[63:32];
        e.last  = (i == n - 1);
        rows_due.push_back(e);
      end
    endfunction

    function void check_row(logic [OutDataW-1:0] data, logic last);
      stamp_row_t act, exp_row;
      act = stamp_row_t'({last, data[CoordW*2+MaskW+ColorW-1:0]});
      if (rows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row beat: y=%0d left=%0d mask=%h color=%h last=%b",
                   $signed(act.row_y), $signed(act.left), act.mask, act.color, act.last);
        return;
      end
      exp_row = rows_due.pop_front();
      if (act.row_y !== exp_row.row_y || act.left !== exp_row.left ||
          act.mask !== exp_row.mask || act.color !== exp_row.color ||
          act.last !== exp_row.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("row mismatch: exp y=%0d left=%0d mask=%h color=%h last=%b",
                   $signed(exp_row.row_y), $signed(exp_row.left), exp_row.mask,
                   exp_row.color, exp_row.last);
          $display("              got y=%0d left=%0d mask=%h color=%h last=%b",
                   $signed(act.row_y), $signed(act.left), act.mask, act.color,
                   act.last);
        end
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // x_quarter, y_quarter, paint_color
  logic [InUserW-1:0]  s_axis_tuser  = '0;   // shape
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // row_y, row_left, pixel_mask, row_color
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  stamp_scoreboard sb = new();
  int send_idle_pct = 31;
  int recv_idle_pct = 79;
  int hold_reqs     = 0;

  subpixel_dot_sprite_rows_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("subpixel_dot_sprite_rows_top verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_dot(s_axis_tdata, s_axis_tuser);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_row(m_axis_tdata, m_axis_tlast);
  end

  // output side: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served != hold_reqs) begin
        hold_left = HoldLen;
        holds_served++;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_dot(logic [15:0] x, logic [15:0] y, logic [1:0] shp, logic [31:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {color, y, x};
    s_axis_tuser  <= shp;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] rand_coord(int dim);
    int v;
    if ($urandom_range(3) == 0) return 16'($urandom());
    v = $urandom_range(dim * 4 + 127) - 64;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  task automatic send_random_dots(int count);
    logic [1:0] shp;
    repeat (count) begin
      shp = ($urandom_range(9) == 0) ? ShapeUnknown : 2'($urandom_range(2));
      send_dot(rand_coord(sb.width), rand_coord(sb.height), shp, $urandom());
    end
  endtask

  // settle past the edge so the last accepted dot is already noted
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DOT_RADIUS:    sb.radius = value & 32'h7;
      REG_WINDOW_WIDTH:  sb.width  = value & 32'h3fff;
      REG_WINDOW_HEIGHT: sb.height = value & 32'h3fff;
      default: ;
    endcase
  endtask

  task automatic reconfigure(int unsigned r, int unsigned w, int unsigned h);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(REG_DOT_RADIUS, r);
    write_reg(REG_WINDOW_WIDTH, w);
    write_reg(REG_WINDOW_HEIGHT, h);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed dots at reset settings
    send_dot(16'h0000, 16'h0000, SHAPE_CIRCLE, 32'h0000_0000);
    send_dot(16'h7fff, 16'h7fff, SHAPE_RING, 32'hffff_ffff);
    send_dot(16'h8000, 16'h8000, SHAPE_CROSS, 32'ha5a5_5a5a);
    send_dot(16'd400, 16'd400, ShapeUnknown, 32'h5a5a_a5a5);
    for (int k = 0; k < 4; k++) begin
      for (int sh = 0; sh < 3; sh++) begin
        send_dot(16'(1000 + k), 16'(1200 + 3 - k), 2'(sh), $urandom());
      end
    end
    send_dot(16'(3840 * 4 - 10), 16'(2160 * 4 - 6), SHAPE_CIRCLE, 32'h1234_5678);
    send_dot(16'hffec, 16'd8, SHAPE_CROSS, 32'h8765_4321);

    send_random_dots(32);

    send_idle_pct = 79;
    recv_idle_pct = 31;
    reconfigure(3, 200, 120);
    send_random_dots(45);
    reconfigure(0, 0, 16383);
    send_random_dots(6);
    reconfigure(2, 16383, 0);
    send_random_dots(6);
    reconfigure(6, 1, 1);
    send_dot(16'h0000, 16'h0000, SHAPE_CIRCLE, $urandom());
    send_dot(16'h0003, 16'h0002, SHAPE_CROSS, $urandom());
    send_random_dots(4);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    reconfigure(7, 8192, 8192);

    // fill the pipe against a long output hold-off, then drain
    hold_reqs <= hold_reqs + 1;
    send_random_dots(16);
    wait_drained();
    send_random_dots(14);
    reconfigure(4, 640, 480);
    send_random_dots(15);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("subpixel_dot_sprite_rows_top verification clean");
    end else begin
      $display("subpixel_dot_sprite_rows_top verification failed");
    end
    $finish;
  end

endmodule
